// ===== design/rqs_pkg.sv =====
// Package for the ready queue scheduler: depth constants, codes and payload types.
// Used by rqs_sel and ready_queue_scheduler; depends on nothing.
`timescale 1ns / 1ps

package rqs_pkg;

  // Ready table geometry
  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_DATA_W  = 16;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // Scheduling policy
  typedef enum logic [1:0] {
    MODE_FIFO = 2'd0,
    MODE_SJF  = 2'd1,
    MODE_PRIO = 2'd2,
    MODE_RR   = 2'd3
  } mode_e;

  // Configuration register indexes
  typedef enum logic {
    CFG_MODE    = 1'b0,
    CFG_QUANTUM = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    KIND_ENQ  = 1'b0,
    KIND_DISP = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_ENQUEUED   = 2'd0,
    ST_FULL       = 2'd1,
    ST_DISPATCHED = 2'd2,
    ST_EMPTY      = 2'd3
  } status_e;

  // One ready table entry
  typedef struct packed {
    logic [7:0]  id;
    logic [7:0]  prio;
    logic [15:0] burst;
  } entry_t;

  // Input item
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  job_id;
    logic [7:0]  priority_req;
    logic [15:0] burst_len;
  } rqs_in_t;

  // Result item
  typedef struct packed {
    status_e     status;
    logic [7:0]  out_job_id;
    logic [7:0]  out_priority;
    logic [15:0] run_time;
    logic [15:0] remaining_after;
    logic        burst_done;
  } rqs_out_t;

  // Compare request from the scan sequencer to the selector
  typedef struct packed {
    logic vld;
    idx_t idx;
  } cmp_t;

endpackage

// ===== design/ready_queue_scheduler.sv =====
// Ready queue scheduler top level: sequencer, ready table memory, config and result register.
// Depends on rqs_pkg and rqs_sel.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) takes enqueue or dispatch
//   items; the output channel (out_valid_o / out_stall_i / out_data_o) returns one
//   result per item. Config writes (cfg_valid_i / cfg_ready_o, index and data) set
//   the policy and the round robin quantum; issue them only while the block is idle.
//   Enqueue and empty-table dispatch: result valid in the cycle after the transfer.
//   Dispatch with the winner at slot B: a scan of every queued entry through the
//   single table read port and the shared comparator, a move up by one slot for
//   each entry behind the winner, then the drain, pick and finish steps.
//   One item is worked on at a time: enqueues can follow every cycle while the
//   output is not stalled, and a dispatch holds off the next input transfer until
//   its result is registered. in_stall_o is high while a dispatch runs and while a
//   finished result sits in the output register with out_stall_i high.
//   A stalled result holds in the output register until its transfer.
//   Reset empties the table (count only, no clearing pass), sets FIFO mode and a
//   quantum of 10.
`timescale 1ns / 1ps

module ready_queue_scheduler (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  rqs_pkg::rqs_in_t                  in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output rqs_pkg::rqs_out_t                 out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  rqs_pkg::cfg_idx_e                 cfg_index_i,
  input  logic [rqs_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import rqs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SDRAIN,
    S_PICK,
    S_SHIFT,
    S_FINISH
  } state_e;

  state_e      state_q, state_d;
  cnt_t        count_q, count_d;
  cnt_t        cnt_m1;
  idx_t        scan_q, scan_d;
  idx_t        sh_q, sh_d;
  logic        cvld_q, cvld_d;
  idx_t        cidx_q, cidx_d;
  logic        wpend_q, wpend_d;
  idx_t        wa_q, wa_d;
  logic        out_vld_q, out_vld_d;
  rqs_out_t    out_q, out_d;
  logic        load_out;
  mode_e       mode_q;
  logic [15:0] quantum_q;

  entry_t      mem [QUEUE_DEPTH];
  entry_t      rd_data_q;
  idx_t        rd_addr;
  logic        we;
  idx_t        wa;
  entry_t      wd;

  logic        in_acc;
  logic        out_free;
  logic        rr_split;
  idx_t        best_idx;
  entry_t      best_entry;
  cmp_t        cmp;

  // Handshakes
  assign out_free    = !out_vld_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE) || !out_free;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  assign cnt_m1   = count_q - 1'b1;
  assign rr_split = (mode_q == MODE_RR) && (best_entry.burst > quantum_q);

  // Shared comparator
  assign cmp.vld = cvld_q;
  assign cmp.idx = cidx_q;

  rqs_sel u_sel (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mode_i       (mode_q),
    .cmp_i        (cmp),
    .entry_i      (rd_data_q),
    .best_idx_o   (best_idx),
    .best_entry_o (best_entry)
  );

  // Sequencer next state, memory port control and result formatting
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    scan_d    = scan_q;
    sh_d      = sh_q;
    cvld_d    = 1'b0;
    cidx_d    = scan_q;
    wpend_d   = 1'b0;
    wa_d      = sh_q;
    out_vld_d = out_vld_q && out_stall_i;
    load_out  = 1'b0;
    out_d     = '0;
    rd_addr   = scan_q;
    we        = 1'b0;
    wa        = wa_q;
    wd        = rd_data_q;

    // Pending compaction write: entry read last cycle moves up one slot
    if (wpend_q) begin
      we = 1'b1;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_data_i.kind == KIND_ENQ) begin
            load_out = 1'b1;
            if (count_q == cnt_t'(QUEUE_DEPTH)) begin
              out_d.status = ST_FULL;
            end else begin
              we           = 1'b1;
              wa           = count_q[IDX_W-1:0];
              wd.id        = in_data_i.job_id;
              wd.prio      = in_data_i.priority_req;
              wd.burst     = in_data_i.burst_len;
              count_d      = count_q + 1'b1;
              out_d.status = ST_ENQUEUED;
            end
          end else if (count_q == '0) begin
            load_out     = 1'b1;
            out_d.status = ST_EMPTY;
          end else begin
            scan_d  = '0;
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        rd_addr = scan_q;
        cvld_d  = 1'b1;
        cidx_d  = scan_q;
        if (cnt_t'(scan_q) == cnt_m1) begin
          state_d = S_SDRAIN;
        end else begin
          scan_d = idx_t'(scan_q + 1'b1);
        end
      end
      S_SDRAIN: begin
        // last compare lands this cycle
        state_d = S_PICK;
      end
      S_PICK: begin
        sh_d    = best_idx;
        state_d = S_SHIFT;
      end
      S_SHIFT: begin
        if (cnt_t'(sh_q) < cnt_m1) begin
          rd_addr = idx_t'(sh_q + 1'b1);
          wpend_d = 1'b1;
          wa_d    = sh_q;
          sh_d    = idx_t'(sh_q + 1'b1);
        end else begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          load_out           = 1'b1;
          out_d.status       = ST_DISPATCHED;
          out_d.out_job_id   = best_entry.id;
          out_d.out_priority = best_entry.prio;
          if (rr_split) begin
            out_d.run_time        = quantum_q;
            out_d.remaining_after = best_entry.burst - quantum_q;
            out_d.burst_done      = 1'b0;
            // requeue at the tail, into the slot the job just freed
            we       = 1'b1;
            wa       = cnt_m1[IDX_W-1:0];
            wd.id    = best_entry.id;
            wd.prio  = best_entry.prio;
            wd.burst = best_entry.burst - quantum_q;
          end else begin
            out_d.run_time        = best_entry.burst;
            out_d.remaining_after = '0;
            out_d.burst_done      = 1'b1;
            count_d               = cnt_m1;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (load_out) begin
      out_vld_d = 1'b1;
    end
  end

  // Control state and config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      scan_q    <= '0;
      sh_q      <= '0;
      cvld_q    <= 1'b0;
      cidx_q    <= '0;
      wpend_q   <= 1'b0;
      wa_q      <= '0;
      out_vld_q <= 1'b0;
      mode_q    <= MODE_FIFO;
      quantum_q <= 16'd10;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      scan_q    <= scan_d;
      sh_q      <= sh_d;
      cvld_q    <= cvld_d;
      cidx_q    <= cidx_d;
      wpend_q   <= wpend_d;
      wa_q      <= wa_d;
      out_vld_q <= out_vld_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_MODE:    mode_q    <= mode_e'(cfg_data_i[1:0]);
          CFG_QUANTUM: quantum_q <= cfg_data_i;
          default:     mode_q    <= mode_q;
        endcase
      end
    end
  end

  // Result register payload
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= out_d;
    end
  end

  // Ready table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data_q <= mem[rd_addr];
  end

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cnt_t'(QUEUE_DEPTH))
    else $error("ready count beyond table depth");

  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> (state_q == S_IDLE))
    else $error("input transfer outside idle");

  a_wpend_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wpend_q |-> (state_q == S_SHIFT))
    else $error("compaction write outside shift phase");

  a_enq_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_data_i.kind == KIND_ENQ) && (count_q != cnt_t'(QUEUE_DEPTH)))
    |=> (count_q == cnt_t'($past(count_q) + 1'b1)))
    else $error("enqueue did not grow the table");

  a_done_rest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (out_q.status == ST_DISPATCHED) && out_q.burst_done)
    |-> (out_q.remaining_after == '0))
    else $error("finished burst with time left");

endmodule

// ===== design/rqs_sel.sv =====
// Shared compare unit: walks the scanned entries one per cycle and keeps the best one.
// Depends on rqs_pkg.
`timescale 1ns / 1ps

module rqs_sel (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rqs_pkg::mode_e  mode_i,
  input  rqs_pkg::cmp_t   cmp_i,
  input  rqs_pkg::entry_t entry_i,
  output rqs_pkg::idx_t   best_idx_o,
  output rqs_pkg::entry_t best_entry_o
);
  import rqs_pkg::*;

  idx_t   best_idx_q;
  entry_t best_entry_q;
  logic   take;

  // Strict compares so the older entry wins a tie
  always_comb begin
    take = 1'b0;
    if (cmp_i.idx == '0) begin
      take = 1'b1;
    end else begin
      case (mode_i)
        MODE_SJF:  take = entry_i.burst < best_entry_q.burst;
        MODE_PRIO: take = entry_i.prio > best_entry_q.prio;
        default:   take = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_idx_q <= '0;
    end else if (cmp_i.vld && take) begin
      best_idx_q <= cmp_i.idx;
    end
  end

  // Winning entry payload
  always_ff @(posedge clk_i) begin
    if (cmp_i.vld && take) begin
      best_entry_q <= entry_i;
    end
  end

  assign best_idx_o   = best_idx_q;
  assign best_entry_o = best_entry_q;

endmodule
